FILE: design/cbd_pkg.sv
// Shared types and constants for the cassette block deframer.
// Holds the result word layout, the sync and block-type byte codes and the FF run constants.
// No dependencies.
`default_nettype none

package cbd_pkg;

    // Tape byte codes
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_FF   = 8'hFF;
    localparam logic [7:0] BYTE_SYNC = 8'h3C;

    // Block types
    localparam logic [1:0] BLK_HEADER = 2'd0;
    localparam logic [1:0] BLK_DATA   = 2'd1;
    localparam logic [1:0] BLK_END    = 2'd2;

    // Result kinds
    localparam logic RES_PAYLOAD   = 1'b0;
    localparam logic RES_BLOCK_END = 1'b1;

    // Configuration
    localparam logic [3:0] MIN_FF_RUN_RESET = 4'd2;
    localparam logic [3:0] FF_RUN_MAX       = 4'd15;

    // One result word
    typedef struct packed {
        logic       result_kind;
        logic [1:0] block_type;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] length_of_block;
        logic       checksum_ok;
        logic       any_error;
    } cbd_result_t;

endpackage

`default_nettype wire

FILE: design/cbd_core.sv
// Deframer state machine: sync hunt, block phases, running checksum and sticky error.
// Updates its state once per advanced byte and forms the result word combinationally.
// Depends on cbd_pkg.
`default_nettype none

module cbd_core
    import cbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic [7:0]  byte_in,
    input  wire logic [3:0]  min_ff_run,
    output cbd_result_t      res,
    output logic             res_hit
);

    // Phase codes
    localparam logic [1:0] PH_HUNT = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    logic [1:0] phase_reg,          phase_next;
    logic       sync_armed_reg,     sync_armed_next;
    logic [3:0] ff_run_reg,         ff_run_next;
    logic [7:0] prev_hunt_byte_reg, prev_hunt_byte_next;
    logic [1:0] current_type_reg,   current_type_next;
    logic [7:0] current_length_reg, current_length_next;
    logic [7:0] data_index_reg,     data_index_next;
    logic [7:0] running_sum_reg,    running_sum_next;
    logic       error_flag_reg,     error_flag_next;

    logic [7:0] sum_add;
    logic [7:0] index_inc;
    logic       sum_match;
    logic       start_blk;
    logic [1:0] start_type;

    assign sum_add   = running_sum_reg + byte_in;
    assign index_inc = data_index_reg + 8'd1;
    assign sum_match = (running_sum_reg == byte_in);

    // Block opener decode while sync is armed
    always_comb
    begin
        start_blk  = 1'b0;
        start_type = BLK_HEADER;
        if (sync_armed_reg)
        begin
            case (byte_in)
                BYTE_ZERO:
                begin
                    start_blk  = 1'b1;
                    start_type = BLK_HEADER;
                end
                BYTE_ONE:
                begin
                    start_blk  = 1'b1;
                    start_type = BLK_DATA;
                end
                BYTE_FF:
                begin
                    start_blk  = 1'b1;
                    start_type = BLK_END;
                end
                default:
                begin
                    start_blk  = 1'b0;
                    start_type = BLK_HEADER;
                end
            endcase
        end
    end

    // Next state and result
    always_comb
    begin
        phase_next          = phase_reg;
        sync_armed_next     = sync_armed_reg;
        ff_run_next         = ff_run_reg;
        prev_hunt_byte_next = prev_hunt_byte_reg;
        current_type_next   = current_type_reg;
        current_length_next = current_length_reg;
        data_index_next     = data_index_reg;
        running_sum_next    = running_sum_reg;
        error_flag_next     = error_flag_reg;

        res_hit                 = 1'b0;
        res.result_kind         = RES_PAYLOAD;
        res.block_type          = current_type_reg;
        res.payload_byte        = 8'd0;
        res.byte_index          = 8'd0;
        res.length_of_block     = current_length_reg;
        res.checksum_ok         = 1'b0;
        res.any_error           = error_flag_reg;

        case (phase_reg)
            PH_LEN:
            begin
                current_length_next = byte_in;
                running_sum_next    = sum_add;
                data_index_next     = 8'd0;
                phase_next          = (byte_in == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                res_hit          = 1'b1;
                res.payload_byte = byte_in;
                res.byte_index   = data_index_reg;
                running_sum_next = sum_add;
                data_index_next  = index_inc;
                if (index_inc == current_length_reg)
                    phase_next = PH_SUM;
            end
            PH_SUM:
            begin
                res_hit         = 1'b1;
                res.result_kind = RES_BLOCK_END;
                res.checksum_ok = sum_match;
                res.any_error   = error_flag_reg | ~sum_match;
                error_flag_next = error_flag_reg | ~sum_match;
                phase_next      = PH_HUNT;
                sync_armed_next = 1'b0;
                ff_run_next     = 4'd0;
            end
            default:
            begin
                // Hunting: every byte is remembered, the type byte included
                prev_hunt_byte_next = byte_in;
                if (start_blk)
                begin
                    current_type_next = start_type;
                    running_sum_next  = byte_in;
                    sync_armed_next   = 1'b0;
                    ff_run_next       = 4'd0;
                    phase_next        = PH_LEN;
                end
                else if (byte_in == BYTE_ZERO)
                    ff_run_next = 4'd0;
                else if (byte_in == BYTE_FF)
                begin
                    if (ff_run_reg != FF_RUN_MAX)
                        ff_run_next = ff_run_reg + 4'd1;
                end
                else if (byte_in == BYTE_SYNC)
                begin
                    if ((ff_run_reg >= min_ff_run) && (prev_hunt_byte_reg == BYTE_ONE))
                    begin
                        sync_armed_next = 1'b1;
                        ff_run_next     = 4'd0;
                    end
                end
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_HUNT;
            sync_armed_reg     <= 1'b0;
            ff_run_reg         <= 4'd0;
            prev_hunt_byte_reg <= 8'd0;
            current_type_reg   <= BLK_HEADER;
            current_length_reg <= 8'd0;
            data_index_reg     <= 8'd0;
            running_sum_reg    <= 8'd0;
            error_flag_reg     <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            sync_armed_reg     <= sync_armed_next;
            ff_run_reg         <= ff_run_next;
            prev_hunt_byte_reg <= prev_hunt_byte_next;
            current_type_reg   <= current_type_next;
            current_length_reg <= current_length_next;
            data_index_reg     <= data_index_next;
            running_sum_reg    <= running_sum_next;
            error_flag_reg     <= error_flag_next;
        end
    end

`ifndef SYNTHESIS
    // Error flag is sticky
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_flag_reg |=> error_flag_reg)
        else $error("error flag cleared");

    // In the payload phase the index stays below the block length
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (data_index_reg < current_length_reg))
        else $error("payload index out of range");

    // Sync is only armed while hunting
    a_sync_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        sync_armed_reg |-> (phase_reg == PH_HUNT))
        else $error("sync armed inside a block");

    // Block end words only come from the checksum phase
    a_end_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (res_hit && (res.result_kind == RES_BLOCK_END)) |-> (phase_reg == PH_SUM))
        else $error("block end outside checksum phase");
`endif

endmodule

`default_nettype wire

FILE: design/cassette_block_deframer.sv
// An accepted byte is registered in the input stage, its result word in the result register.
// One byte per cycle unless stalled, set by the single-pass state update and 8-bit sum adder.
// Payload bytes give one word each, checksum bytes one block-end word, all others none.
// Reset: asynchronous, clears the deframer to hunting with min_ff_run at 2 and no error.
// Top level of the cassette block deframer; depends on cbd_pkg and cbd_core.
`default_nettype none

module cassette_block_deframer
    import cbd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [3:0]  cfg_wr_data,
    // byte input
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  tape_byte,
    // result output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             result_kind,
    output logic [1:0]       block_type,
    output logic [7:0]       payload_byte,
    output logic [7:0]       byte_index,
    output logic [7:0]       length_of_block,
    output logic             checksum_ok,
    output logic             any_error
);

    logic [3:0]  min_ff_run_reg;
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        out_valid_reg;
    cbd_result_t out_word_reg;
    cbd_result_t core_res;
    logic        core_hit;
    logic        out_free;
    logic        advance;

    // Stage handshake: the input stage moves when the result register can take a word
    assign out_free = ~out_valid_reg | ~out_stall;
    assign advance  = s1_valid_reg & out_free;
    assign in_stall = s1_valid_reg & ~out_free;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_ff_run_reg <= MIN_FF_RUN_RESET;
        else if (cfg_wr_en)
            min_ff_run_reg <= cfg_wr_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s1_byte_reg <= tape_byte;
    end

    cbd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .byte_in    (s1_byte_reg),
        .min_ff_run (min_ff_run_reg),
        .res        (core_res),
        .res_hit    (core_hit)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= advance & core_hit;
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_hit)
            out_word_reg <= core_res;
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_word_reg.result_kind;
    assign block_type      = out_word_reg.block_type;
    assign payload_byte    = out_word_reg.payload_byte;
    assign byte_index      = out_word_reg.byte_index;
    assign length_of_block = out_word_reg.length_of_block;
    assign checksum_ok     = out_word_reg.checksum_ok;
    assign any_error       = out_word_reg.any_error;

`ifndef SYNTHESIS
    // Input only stalls with a byte held in the input stage
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stall with empty input stage");

    // A stalled input stage keeps its byte
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> (s1_valid_reg && $stable(s1_byte_reg)))
        else $error("input stage lost a byte under stall");

    // A word is never overwritten while stalled at the output
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !advance)
        else $error("input stage advanced into a full result register");
`endif

endmodule

`default_nettype wire
